// ===== design/kmp_pattern_matcher_top_defines.svh =====
// Assertion macros used by the matcher control RTL (kmp_ctrl).
`ifndef KMP_PATTERN_MATCHER_TOP_DEFINES_SVH
`define KMP_PATTERN_MATCHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define KMP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("kmp assertion failed");

`define KMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kmp assertion failed");

`else

`define KMP_ASSERT(lbl, clk, rstn, prop)

`define KMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== design/kmp_pkg.sv =====
package kmp_pkg;

    localparam int MAX_PATTERN_DEF   = 32;
    localparam int POSITION_BITS_DEF = 16;

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_WALK,
        ST_MFAIL
    } kmp_state_t;

endpackage

// ===== design/kmp_ram.sv =====
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/kmp_ctrl.sv =====
`include "kmp_pattern_matcher_top_defines.svh"

module kmp_ctrl #(
    parameter int MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_cmd,
    input  logic [7:0]                     in_byte,
    input  logic                           in_restart,
    output logic                           wr_en,
    output logic [$clog2(MAX_PATTERN)-1:0] wr_addr,
    output logic [7:0]                     pat_wr_data,
    output logic [$clog2(MAX_PATTERN)-1:0] fail_wr_data,
    output logic                           pat_rd_en,
    output logic [$clog2(MAX_PATTERN)-1:0] pat_rd_addr,
    input  logic [7:0]                     pat_rd_data,
    output logic                           fail_rd_en,
    output logic [$clog2(MAX_PATTERN)-1:0] fail_rd_addr,
    input  logic [$clog2(MAX_PATTERN)-1:0] fail_rd_data,
    input  logic                           out_free,
    output logic                           emit_valid,
    output logic [POSITION_BITS-1:0]       emit_pos
);

    import kmp_pkg::*;

    localparam int IW = $clog2(MAX_PATTERN);
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int PW = POSITION_BITS;
    localparam int CW = (PW > LW) ? PW : LW;
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

    kmp_state_t state_reg, state_next;

    logic          cmd_reg, cmd_next;
    logic [7:0]    byte_reg, byte_next;
    logic [LW-1:0] len_reg, len_next;
    logic [IW-1:0] bpl_reg, bpl_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] match_reg, match_next;
    logic [PW-1:0] tp_reg, tp_next;
    logic [PW-1:0] here_reg, here_next;

    logic [LW-1:0] eff_len;
    logic [IW-1:0] eff_match;
    logic [PW-1:0] eff_tp;
    logic [LW-1:0] k_inc;
    logic [CW-1:0] here_w;
    logic [CW-1:0] back_w;

    assign eff_len   = (in_restart && in_cmd == CMD_PATTERN) ? '0 : len_reg;
    assign eff_match = in_restart ? '0 : match_reg;
    assign eff_tp    = in_restart ? '0 : tp_reg;
    assign k_inc     = LW'(k_reg) + LW'(1);

    assign here_w   = CW'(here_reg);
    assign back_w   = CW'(len_reg) - CW'(1);
    assign emit_pos = (here_w >= back_w) ? PW'(here_w - back_w) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            bpl_reg   <= '0;
            match_reg <= '0;
            tp_reg    <= '0;
        end else begin
            len_reg   <= len_next;
            bpl_reg   <= bpl_next;
            match_reg <= match_next;
            tp_reg    <= tp_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        byte_reg <= byte_next;
        k_reg    <= k_next;
        here_reg <= here_next;
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        byte_next    = byte_reg;
        len_next     = len_reg;
        bpl_next     = bpl_reg;
        k_next       = k_reg;
        match_next   = match_reg;
        tp_next      = tp_reg;
        here_next    = here_reg;
        in_ready     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = len_reg[IW-1:0];
        pat_wr_data  = byte_reg;
        fail_wr_data = '0;
        pat_rd_en    = 1'b0;
        pat_rd_addr  = k_reg;
        fail_rd_en   = 1'b0;
        fail_rd_addr = '0;
        emit_valid   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_next   = in_cmd;
                    byte_next  = in_byte;
                    match_next = eff_match;
                    if (in_cmd == CMD_PATTERN) begin
                        tp_next  = eff_tp;
                        len_next = eff_len;
                        if (in_restart) begin
                            bpl_next = '0;
                        end
                        if (eff_len == '0) begin
                            wr_en        = 1'b1;
                            wr_addr      = '0;
                            pat_wr_data  = in_byte;
                            fail_wr_data = '0;
                            len_next     = LW'(1);
                            bpl_next     = '0;
                        end else if (eff_len != LW'(MAX_PATTERN)) begin
                            k_next      = bpl_reg;
                            pat_rd_en   = 1'b1;
                            pat_rd_addr = bpl_reg;
                            state_next  = ST_CMP;
                        end
                    end else begin
                        here_next = eff_tp;
                        tp_next   = (eff_tp == POS_MAX) ? eff_tp : eff_tp + PW'(1);
                        if (len_reg == '0) begin
                            match_next = '0;
                        end else begin
                            k_next      = (LW'(eff_match) >= len_reg) ? '0 : eff_match;
                            pat_rd_en   = 1'b1;
                            pat_rd_addr = (LW'(eff_match) >= len_reg) ? '0 : eff_match;
                            state_next  = ST_CMP;
                        end
                    end
                end
            end
            ST_CMP: begin
                if (pat_rd_data == byte_reg) begin
                    if (cmd_reg == CMD_PATTERN) begin
                        wr_en        = 1'b1;
                        fail_wr_data = k_inc[IW-1:0];
                        bpl_next     = k_inc[IW-1:0];
                        len_next     = len_reg + LW'(1);
                        state_next   = ST_IDLE;
                    end else if (k_inc == len_reg) begin
                        fail_rd_en   = 1'b1;
                        fail_rd_addr = IW'(len_reg - LW'(1));
                        state_next   = ST_MFAIL;
                    end else begin
                        match_next = k_inc[IW-1:0];
                        state_next = ST_IDLE;
                    end
                end else if (k_reg != '0) begin
                    fail_rd_en   = 1'b1;
                    fail_rd_addr = k_reg - IW'(1);
                    state_next   = ST_WALK;
                end else if (cmd_reg == CMD_PATTERN) begin
                    wr_en        = 1'b1;
                    fail_wr_data = '0;
                    bpl_next     = '0;
                    len_next     = len_reg + LW'(1);
                    state_next   = ST_IDLE;
                end else begin
                    match_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK: begin
                k_next      = fail_rd_data;
                pat_rd_en   = 1'b1;
                pat_rd_addr = fail_rd_data;
                state_next  = ST_CMP;
            end
            ST_MFAIL: begin
                if (out_free) begin
                    emit_valid = 1'b1;
                    match_next = fail_rd_data;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `KMP_ASSERT(a_len_bound, aclk, aresetn, len_reg <= LW'(MAX_PATTERN))
    `KMP_ASSERT(a_prefix_bound, aclk, aresetn, (len_reg == '0) || (LW'(bpl_reg) < len_reg))
    `KMP_ASSERT(a_match_bound, aclk, aresetn, (match_reg == '0) || (LW'(match_reg) < len_reg))
    `KMP_ASSERT_NEXT(a_emit_done, aclk, aresetn, emit_valid, state_reg == ST_IDLE)
    `KMP_ASSERT_NEXT(a_pos_hold, aclk, aresetn, !(in_valid && in_ready), $stable(tp_reg))

endmodule

// ===== design/kmp_pattern_matcher_top.sv =====
// A pattern byte is written directly when it is the first and dropped past capacity; others compare and follow links.
// Text bytes are handled in idle on an empty pattern, else they compare and follow each failure link in turn.
// A completed match adds a state that stalls while the previous position still waits on m_ready.
// Each step waits on a registered read of the pattern and failure memories.
// A match position is presented on the cycle after its text byte finishes.
// Synchronous active-low reset empties the pattern and clears the matcher; no memory clearing.
module kmp_pattern_matcher_top #(
    parameter int MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_cmd,
    input  logic [7:0]               s_data_byte,
    input  logic                     s_restart,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [POSITION_BITS-1:0] m_match_position
);

    import kmp_pkg::*;

    localparam int IW = $clog2(MAX_PATTERN);

    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    logic [7:0]               pat_wr_data;
    logic [IW-1:0]            fail_wr_data;
    logic                     pat_rd_en;
    logic [IW-1:0]            pat_rd_addr;
    logic [7:0]               pat_rd_data;
    logic                     fail_rd_en;
    logic [IW-1:0]            fail_rd_addr;
    logic [IW-1:0]            fail_rd_data;
    logic                     out_free;
    logic                     emit_valid;
    logic [POSITION_BITS-1:0] emit_pos;

    logic                     m_valid_reg, m_valid_next;
    logic [POSITION_BITS-1:0] m_pos_reg, m_pos_next;

    kmp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PATTERN)
    ) u_pat_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pat_wr_data),
        .rd_en   (pat_rd_en),
        .rd_addr (pat_rd_addr),
        .rd_data (pat_rd_data)
    );

    kmp_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_PATTERN)
    ) u_fail_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (fail_wr_data),
        .rd_en   (fail_rd_en),
        .rd_addr (fail_rd_addr),
        .rd_data (fail_rd_data)
    );

    kmp_ctrl #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_cmd       (s_cmd),
        .in_byte      (s_data_byte),
        .in_restart   (s_restart),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .pat_wr_data  (pat_wr_data),
        .fail_wr_data (fail_wr_data),
        .pat_rd_en    (pat_rd_en),
        .pat_rd_addr  (pat_rd_addr),
        .pat_rd_data  (pat_rd_data),
        .fail_rd_en   (fail_rd_en),
        .fail_rd_addr (fail_rd_addr),
        .fail_rd_data (fail_rd_data),
        .out_free     (out_free),
        .emit_valid   (emit_valid),
        .emit_pos     (emit_pos)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_pos_next   = m_pos_reg;
        if (emit_valid) begin
            m_valid_next = 1'b1;
            m_pos_next   = emit_pos;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_pos_reg <= m_pos_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_match_position = m_pos_reg;

endmodule

// ===== tb/tb_kmp_pattern_matcher_top.sv =====
module tb_kmp_pattern_matcher_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAXP         = kmp_pkg::MAX_PATTERN_DEF;
    localparam int          PBITS        = kmp_pkg::POSITION_BITS_DEF;
    localparam int unsigned POS_LIMIT    = (1 << PBITS) - 1;
    localparam int          RANDOM_WORDS = 1160;
    localparam int          DRAIN_CYCLES = 100;
    localparam longint      CYCLE_LIMIT  = 3_000_000;

    class kmp_scoreboard;
        byte unsigned     pattern_bytes [MAXP];
        int unsigned      failure_links [MAXP];
        int unsigned      pattern_len;
        int unsigned      prefix_len;
        int unsigned      matched;
        int unsigned      text_pos;
        logic [PBITS-1:0] expected_positions [$];
        int               errors;
        int               pattern_words;
        int               text_words;
        int               checked;

        function new();
            pattern_len   = 0;
            prefix_len    = 0;
            matched       = 0;
            text_pos      = 0;
            errors        = 0;
            pattern_words = 0;
            text_words    = 0;
            checked       = 0;
        endfunction

        function void note_word(logic cmd, logic [7:0] b, logic rs);
            int unsigned k;
            int unsigned here;
            if (rs) begin
                matched  = 0;
                text_pos = 0;
                if (cmd == kmp_pkg::CMD_PATTERN) begin
                    pattern_len = 0;
                    prefix_len  = 0;
                end
            end
            if (cmd == kmp_pkg::CMD_PATTERN) begin
                pattern_words++;
                if (pattern_len < MAXP) begin
                    pattern_bytes[pattern_len] = b;
                    k = 0;
                    if (pattern_len != 0) begin
                        k = prefix_len;
                        while (k > 0 && b != pattern_bytes[k])
                            k = failure_links[k-1];
                        if (b == pattern_bytes[k])
                            k++;
                    end
                    failure_links[pattern_len] = k;
                    prefix_len = k;
                    pattern_len++;
                end
            end else begin
                text_words++;
                here = text_pos;
                if (text_pos < POS_LIMIT)
                    text_pos++;
                if (pattern_len == 0) begin
                    matched = 0;
                end else begin
                    k = (matched >= pattern_len) ? 0 : matched;
                    while (k > 0 && b != pattern_bytes[k])
                        k = failure_links[k-1];
                    if (b == pattern_bytes[k])
                        k++;
                    if (k == pattern_len) begin
                        expected_positions = {expected_positions,
                            PBITS'((here >= pattern_len - 1) ? here - (pattern_len - 1) : 0)};
                        k = failure_links[pattern_len-1];
                    end
                    matched = k;
                end
            end
        endfunction

        function void check_match(logic [PBITS-1:0] got);
            logic [PBITS-1:0] want;
            if (expected_positions.size() == 0) begin
                $error("match_position: expected no word, actual %0d", got);
                errors++;
            end else begin
                want = expected_positions.pop_front();
                checked++;
                if (got !== want) begin
                    $error("match_position: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    logic             s_cmd       = kmp_pkg::CMD_PATTERN;
    logic [7:0]       s_data_byte = 8'h00;
    logic             s_restart   = 1'b0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    logic [PBITS-1:0] m_match_position;

    bit               no_idle     = 1'b0;
    longint           cycles      = 0;
    kmp_scoreboard    sb          = new();

    kmp_pattern_matcher_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_data_byte      (s_data_byte),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_position (m_match_position)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_kmp_pattern_matcher_top failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= 22);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_match(m_match_position);
    end

    task automatic send_word(input logic cmd, input logic [7:0] b, input logic rs);
        while (!no_idle && $urandom_range(0, 99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_data_byte <= b;
        s_restart   <= rs;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_word(cmd, b, rs);
    endtask

    function automatic logic [7:0] pick_symbol(logic [7:0] a0, logic [7:0] a1, logic [7:0] a2);
        if ($urandom_range(0, 4) == 0)
            return a2;
        return $urandom_range(0, 1) ? a1 : a0;
    endfunction

    initial begin
        logic [7:0] a0, a1, a2, sym;
        logic [7:0] pat [MAXP+4];
        int         plen, tlen, i, j, r, random_words;
        bit         have_pattern;

        random_words = 0;
        have_pattern = 1'b0;
        plen         = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Text against an empty pattern, then a short pattern at the byte extremes.
        send_word(kmp_pkg::CMD_TEXT, 8'h00, 1'b1);
        send_word(kmp_pkg::CMD_TEXT, 8'hFF, 1'b0);
        send_word(kmp_pkg::CMD_PATTERN, 8'hFF, 1'b1);
        send_word(kmp_pkg::CMD_PATTERN, 8'h00, 1'b0);
        send_word(kmp_pkg::CMD_PATTERN, 8'hFF, 1'b0);
        send_word(kmp_pkg::CMD_TEXT, 8'hFF, 1'b1);
        send_word(kmp_pkg::CMD_TEXT, 8'h00, 1'b0);
        send_word(kmp_pkg::CMD_TEXT, 8'hFF, 1'b0);
        send_word(kmp_pkg::CMD_TEXT, 8'h00, 1'b0);
        send_word(kmp_pkg::CMD_TEXT, 8'hFF, 1'b0);
        // The pattern grows while the matcher is partway through the text.
        send_word(kmp_pkg::CMD_PATTERN, 8'h00, 1'b0);
        send_word(kmp_pkg::CMD_TEXT, 8'h00, 1'b0);
        send_word(kmp_pkg::CMD_TEXT, 8'hFF, 1'b0);
        send_word(kmp_pkg::CMD_TEXT, 8'h00, 1'b0);
        send_word(kmp_pkg::CMD_TEXT, 8'hFF, 1'b1);
        send_word(kmp_pkg::CMD_TEXT, 8'h00, 1'b0);
        send_word(kmp_pkg::CMD_TEXT, 8'hFF, 1'b0);
        send_word(kmp_pkg::CMD_TEXT, 8'h00, 1'b0);
        send_word(kmp_pkg::CMD_PATTERN, 8'h00, 1'b1);
        send_word(kmp_pkg::CMD_TEXT, 8'h00, 1'b0);
        send_word(kmp_pkg::CMD_TEXT, 8'hFF, 1'b0);
        send_word(kmp_pkg::CMD_TEXT, 8'h00, 1'b0);

        // A pattern longer than the store holds.
        for (i = 0; i < MAXP + 2; i++)
            send_word(kmp_pkg::CMD_PATTERN, 8'h5A, i == 0);
        for (i = 0; i < MAXP + 3; i++)
            send_word(kmp_pkg::CMD_TEXT, 8'h5A, i == 0);

        while (random_words < RANDOM_WORDS) begin
            no_idle = (random_words >= 400 && random_words < 750);
            a0 = 8'($urandom);
            a1 = 8'($urandom);
            a2 = 8'($urandom);
            if (!have_pattern || $urandom_range(0, 3) != 0) begin
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MAXP + 4)
                                                  : $urandom_range(1, 6);
                for (i = 0; i < plen; i++) begin
                    pat[i] = pick_symbol(a0, a1, a2);
                    send_word(kmp_pkg::CMD_PATTERN, pat[i], i == 0);
                    random_words++;
                end
                have_pattern = 1'b1;
            end
            tlen = $urandom_range(8, 48);
            i = 0;
            while (i < tlen) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    sym = pick_symbol(a0, a1, a2);
                    if (plen < MAXP + 4) begin
                        pat[plen] = sym;
                        plen++;
                    end
                    send_word(kmp_pkg::CMD_PATTERN, sym, 1'b0);
                end else if (r < 6) begin
                    send_word(kmp_pkg::CMD_TEXT, 8'($urandom), i == 0);
                end else if (r < 8) begin
                    send_word(kmp_pkg::CMD_TEXT, pick_symbol(a0, a1, a2), 1'b1);
                end else if (r < 32) begin
                    for (j = 0; j < plen && j < MAXP; j++) begin
                        send_word(kmp_pkg::CMD_TEXT, pat[j], i == 0 && j == 0);
                        random_words++;
                    end
                end else begin
                    send_word(kmp_pkg::CMD_TEXT, pick_symbol(a0, a1, a2), i == 0);
                end
                random_words++;
                i++;
            end
        end

        // A fresh two-byte pattern against a fresh text, sent without gaps.
        no_idle = 1'b1;
        send_word(kmp_pkg::CMD_PATTERN, 8'hFF, 1'b1);
        send_word(kmp_pkg::CMD_PATTERN, 8'hFE, 1'b0);
        send_word(kmp_pkg::CMD_TEXT, 8'hFF, 1'b1);
        send_word(kmp_pkg::CMD_TEXT, 8'hFE, 1'b0);
        s_valid <= 1'b0;
        no_idle = 1'b0;

        while (sb.expected_positions.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        while (sb.expected_positions.size() != 0) begin
            $error("match_position: expected %0d, never arrived",
                   sb.expected_positions.pop_front());
            sb.errors++;
        end

        $display("Sent %0d pattern words and %0d text words; %0d match positions compared.",
                 sb.pattern_words, sb.text_words, sb.checked);
        $display("Covered an empty pattern, an overfull pattern, mid-text growth and "
                 , "restarts of pattern and text.");
        if (sb.errors == 0) begin
            $display("tb_kmp_pattern_matcher_top passed");
        end else begin
            $display("tb_kmp_pattern_matcher_top failed");
        end
        $finish;
    end
endmodule
